// File: hdl/hsv2rgb_pkg.sv
// Shared types, constants and helpers for the HSV to RGB converter.
// Depends on nothing; imported by every module of the block.
package hsv2rgb_pkg;

  // Hue is in sixteenths of a degree: one 60 degree sector spans 960 codes
  localparam int unsigned HueSector   = 960;
  localparam int unsigned UnitScale   = 255;
  // 255 * 960, the common denominator of q and t
  localparam int unsigned FracScale   = 244800;
  // floor(x / 15) == (x * Recip15) >> 16 for every 10-bit x
  localparam int unsigned Recip15     = 4370;
  // floor(y / 3825) == (y * Recip3825) >> 32 for every y below 2^20
  localparam longint unsigned Recip3825 = 64'd1122868;
  // floor(x / 6) == (x * Recip6) >> 8 for every 7-bit x
  localparam int unsigned Recip6      = 43;

  typedef enum logic [2:0] {
    SecRedYellow   = 3'd0,
    SecYellowGreen = 3'd1,
    SecGreenCyan   = 3'd2,
    SecCyanBlue    = 3'd3,
    SecBlueMagenta = 3'd4,
    SecMagentaRed  = 3'd5
  } sector_e;

  typedef struct packed {
    logic [15:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
  } hsv_pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pixel_t;

  // Reduce a sector count (hue / 960, at most 68) to its sector in the turn
  function automatic sector_e sector_of(input logic [6:0] quo);
    logic [13:0] prod;
    logic [5:0]  turns;
    logic [9:0]  whole;
    logic [6:0]  rem;
    prod  = quo * 7'(Recip6);
    turns = prod[13:8];
    whole = turns * 4'd6;
    rem   = quo - whole[6:0];
    return sector_e'(rem[2:0]);
  endfunction

endpackage

// File: hdl/hsv2rgb_div.sv
// Constant divider: floor(num / 244800) by reciprocal multiplication.
// Depends on hsv2rgb_pkg; used twice in the last stage of the converter.
module hsv2rgb_div
  import hsv2rgb_pkg::*;
(
  input  logic [25:0] num_i,
  output logic [7:0]  quot_o
);

  // 244800 = 64 * 3825: drop the power of two first, it does not change the floor
  logic [19:0] scaled;
  logic [40:0] prod;

  assign scaled = num_i[25:6];
  assign prod   = scaled * 21'(Recip3825);
  assign quot_o = prod[39:32];

endmodule

// File: hdl/hsv_to_rgb_converter.sv
// HSV to RGB pixel converter, four register stages, valid/ready on both sides.
// Throughput one pixel per cycle while the pipeline is not stalled.
// The pipeline advances as one: it stalls only while the result register is full and
// the sink holds ready low.
// Reset (asynchronous, active low) clears the stage valid bits; payload is not reset.
// Depends on hsv2rgb_pkg and hsv2rgb_div.
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  hsv_pixel_t hsv_i,
  input  logic       hsv_valid_i,
  output logic       hsv_ready_o,
  output rgb_pixel_t rgb_o,
  output logic       rgb_valid_o,
  input  logic       rgb_ready_i
);

  // Valid bit of each stage, stage 4 being the result register
  logic [3:0] vld_q, vld_d;
  logic       adv;

  // Advance every stage whenever the result register is empty or being drained
  assign adv         = !vld_q[3] || rgb_ready_i;
  assign hsv_ready_o = adv;
  assign vld_d       = {vld_q[2:0], hsv_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: coarse sector count. hue / 960 == (hue >> 6) / 15, done by reciprocal.
  // ---------------------------------------------------------------------------
  logic [9:0]  s1_x_q;
  logic [5:0]  s1_lo_q;
  logic [6:0]  s1_quo_q, s1_quo_d;
  logic [7:0]  s1_sat_q, s1_val_q;
  logic [22:0] s1_mul;

  assign s1_mul   = hsv_i.hue[15:6] * 13'(Recip15);
  assign s1_quo_d = s1_mul[22:16];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_x_q   <= hsv_i.hue[15:6];
      s1_lo_q  <= hsv_i.hue[5:0];
      s1_quo_q <= s1_quo_d;
      s1_sat_q <= hsv_i.saturation;
      s1_val_q <= hsv_i.brightness;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: position inside the sector, sector in the turn, and the three
  // saturation products. The remainder of x / 15 and the low six hue bits
  // together form fu = hue mod 960.
  // ---------------------------------------------------------------------------
  logic [9:0]  s2_whole;
  logic [9:0]  s2_rem;
  logic [9:0]  s2_fu_d;
  logic [9:0]  s2_cofu;
  sector_e     s2_sec_q;
  logic [7:0]  s2_val_q;
  logic [15:0] s2_pnum_q, s2_pnum_d;
  logic [17:0] s2_sf_q, s2_sf_d;
  logic [17:0] s2_sg_q, s2_sg_d;

  assign s2_whole  = s1_quo_q * 4'd15;
  assign s2_rem    = s1_x_q - s2_whole;
  assign s2_fu_d   = {s2_rem[3:0], s1_lo_q};
  assign s2_cofu   = 10'(HueSector) - s2_fu_d;
  assign s2_pnum_d = s1_val_q * (8'(UnitScale) - s1_sat_q);
  assign s2_sf_d   = s1_sat_q * s2_fu_d;
  assign s2_sg_d   = s1_sat_q * s2_cofu;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_sec_q  <= sector_of(s1_quo_q);
      s2_val_q  <= s1_val_q;
      s2_pnum_q <= s2_pnum_d;
      s2_sf_q   <= s2_sf_d;
      s2_sg_q   <= s2_sg_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: p = pnum / 255 (exact shift-add form for 16-bit operands), and the
  // brightness-scaled numerators of q and t.
  // ---------------------------------------------------------------------------
  logic [16:0] s3_psum;
  logic [17:0] s3_qa, s3_ta;
  sector_e     s3_sec_q;
  logic [7:0]  s3_val_q;
  logic [7:0]  s3_p_q;
  logic [25:0] s3_qm_q, s3_qm_d;
  logic [25:0] s3_tm_q, s3_tm_d;

  assign s3_psum = 17'(s2_pnum_q) + 17'(s2_pnum_q[15:8]) + 17'd1;
  assign s3_qa   = 18'(FracScale) - s2_sf_q;
  assign s3_ta   = 18'(FracScale) - s2_sg_q;
  assign s3_qm_d = s2_val_q * s3_qa;
  assign s3_tm_d = s2_val_q * s3_ta;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_sec_q <= s2_sec_q;
      s3_val_q <= s2_val_q;
      s3_p_q   <= s3_psum[15:8];
      s3_qm_q  <= s3_qm_d;
      s3_tm_q  <= s3_tm_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: divide q and t by 244800, then route v, p, q and t by sector.
  // ---------------------------------------------------------------------------
  logic [7:0] s4_q, s4_t;
  rgb_pixel_t rgb_q, rgb_d;

  hsv2rgb_div u_div_q (
    .num_i  (s3_qm_q),
    .quot_o (s4_q)
  );

  hsv2rgb_div u_div_t (
    .num_i  (s3_tm_q),
    .quot_o (s4_t)
  );

  always_comb begin
    unique case (s3_sec_q)
      SecRedYellow:   rgb_d = '{red: s3_val_q, green: s4_t,     blue: s3_p_q};
      SecYellowGreen: rgb_d = '{red: s4_q,     green: s3_val_q, blue: s3_p_q};
      SecGreenCyan:   rgb_d = '{red: s3_p_q,   green: s3_val_q, blue: s4_t};
      SecCyanBlue:    rgb_d = '{red: s3_p_q,   green: s4_q,     blue: s3_val_q};
      SecBlueMagenta: rgb_d = '{red: s4_t,     green: s3_p_q,   blue: s3_val_q};
      default:        rgb_d = '{red: s3_val_q, green: s3_p_q,   blue: s4_q};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rgb_q <= rgb_d;
    end
  end

  assign rgb_o       = rgb_q;
  assign rgb_valid_o = vld_q[3];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Position inside a sector never reaches a full sector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (s2_fu_d < 10'(HueSector)))
    else $error("hue fraction out of sector range");

  // p never exceeds brightness
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (s3_p_q <= s3_val_q))
    else $error("p exceeds brightness");

  // q and t never exceed brightness
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> ((s4_q <= s3_val_q) && (s4_t <= s3_val_q)))
    else $error("q or t exceeds brightness");

  // An empty result register always lets the pipeline move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[3] |-> hsv_ready_o)
    else $error("pipeline stalled with empty result register");

endmodule

// File: tb/testbench.sv
// Self-checking bench for the HSV to RGB converter: drives HSV pixels, predicts RGB.
// Depends on hsv2rgb_pkg for the pixel structs and sector codes, and on the DUT.
module testbench
  import hsv2rgb_pkg::*;
();

  // 360 degrees in sixteenths of a degree
  localparam int unsigned HueTurn       = 6 * HueSector;
  // Idle cycles with no transfer on either side before the run is abandoned
  localparam int unsigned WatchdogLimit = 400;
  // Cycles to hold after the last result, well past the four-stage pipeline
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned RandomPixels  = 1030;

  // Scoreboard: turns each accepted HSV pixel into the RGB pixel the block owes,
  // and checks results in arrival order against the oldest one outstanding.
  class pixel_scoreboard;
    rgb_pixel_t rgb_due[$];
    int unsigned pixels_in;
    int unsigned pixels_out;
    int unsigned errors;
    int unsigned sector_hits[6];

    // Exact integer HSV to RGB conversion, truncating
    function rgb_pixel_t predict_rgb(hsv_pixel_t px);
      int unsigned h, s, v, fu, p, q, t;
      sector_e     sec;
      rgb_pixel_t  rgb;
      h   = int'(px.hue) % HueTurn;
      s   = px.saturation;
      v   = px.brightness;
      sec = sector_e'(h / HueSector);
      fu  = h % HueSector;
      p   = (v * (UnitScale - s)) / UnitScale;
      q   = (v * (FracScale - s * fu)) / FracScale;
      t   = (v * (FracScale - s * (HueSector - fu))) / FracScale;
      sector_hits[h / HueSector]++;
      case (sec)
        SecRedYellow: begin
          rgb = '{red: v[7:0], green: t[7:0], blue: p[7:0]};
        end
        SecYellowGreen: begin
          rgb = '{red: q[7:0], green: v[7:0], blue: p[7:0]};
        end
        SecGreenCyan: begin
          rgb = '{red: p[7:0], green: v[7:0], blue: t[7:0]};
        end
        SecCyanBlue: begin
          rgb = '{red: p[7:0], green: q[7:0], blue: v[7:0]};
        end
        SecBlueMagenta: begin
          rgb = '{red: t[7:0], green: p[7:0], blue: v[7:0]};
        end
        default: begin
          rgb = '{red: v[7:0], green: p[7:0], blue: q[7:0]};
        end
      endcase
      return rgb;
    endfunction

    function void note_pixel(hsv_pixel_t px);
      pixels_in++;
      rgb_due.push_back(predict_rgb(px));
    endfunction

    function void check_pixel(rgb_pixel_t got);
      rgb_pixel_t want;
      if (rgb_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                 got.red, got.green, got.blue);
        return;
      end
      want = rgb_due.pop_front();
      pixels_out++;
      if (got.red !== want.red) begin
        errors++;
        $display("%0t: red mismatch, expected %0d, got %0d", $time, want.red, got.red);
      end
      if (got.green !== want.green) begin
        errors++;
        $display("%0t: green mismatch, expected %0d, got %0d", $time, want.green, got.green);
      end
      if (got.blue !== want.blue) begin
        errors++;
        $display("%0t: blue mismatch, expected %0d, got %0d", $time, want.blue, got.blue);
      end
    endfunction

    function int unsigned pending();
      return rgb_due.size();
    endfunction

    // Anything still owed at the end of the run is a failure
    function void flush_check();
      if (rgb_due.size() != 0) begin
        errors++;
        $display("%0t: %0d results never arrived", $time, rgb_due.size());
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  hsv_pixel_t hsv_i;
  logic       hsv_valid_i;
  logic       hsv_ready_o;
  rgb_pixel_t rgb_o;
  logic       rgb_valid_o;
  logic       rgb_ready_i;

  pixel_scoreboard sb = new();

  // Idle control: when calm, that side never waits between transfers
  bit          tx_calm;
  bit          rx_calm;
  int unsigned stall_cycles = 0;

  hsv_to_rgb_converter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hsv_i       (hsv_i),
    .hsv_valid_i (hsv_valid_i),
    .hsv_ready_o (hsv_ready_o),
    .rgb_o       (rgb_o),
    .rgb_valid_o (rgb_valid_o),
    .rgb_ready_i (rgb_ready_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Sample both channels at the rising edge; signals were last driven at the
  // falling edge, so the values seen here are the ones the DUT registers.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hsv_valid_i && hsv_ready_o) begin
        sb.note_pixel(hsv_i);
      end
      if (rgb_valid_o && rgb_ready_i) begin
        sb.check_pixel(rgb_o);
      end
      if ((hsv_valid_i && hsv_ready_o) || (rgb_valid_o && rgb_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles = stall_cycles + 1;
      end
      if (stall_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending());
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic int unsigned draw_gap(bit calm);
    if (calm) begin
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic hsv_pixel_t make_px(int unsigned h, int unsigned s, int unsigned v);
    hsv_pixel_t px;
    px.hue        = h[15:0];
    px.saturation = s[7:0];
    px.brightness = v[7:0];
    return px;
  endfunction

  // Hue mix: raw 16-bit codes, one turn, sector edges and the top of the range
  function automatic logic [15:0] pick_hue();
    int unsigned k, off;
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, HueTurn - 1));
      2: begin
        k = $urandom_range(0, 6);
        case ($urandom_range(0, 3))
          0:       off = 0;
          1:       off = 1;
          2:       off = HueSector - 2;
          default: off = HueSector - 1;
        endcase
        return 16'(k * HueSector + off);
      end
      default: return 16'(16'hFFFF - $urandom_range(0, 1000));
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 4))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(0, 3));
      default: return 8'($urandom);
    endcase
  endfunction

  // Present one pixel after a gap, hold it until the transfer, then return at
  // the next falling edge with valid still high so a back-to-back pixel can follow.
  task automatic send_pixel(input hsv_pixel_t px);
    int unsigned gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      hsv_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    hsv_i       = px;
    hsv_valid_i = 1'b1;
    do @(posedge clk_i); while (!hsv_ready_o);
    @(negedge clk_i);
  endtask

  // Drop valid and hold off until every pixel sent so far has come back
  task automatic wait_drained();
    hsv_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Sink: draw a stall per result, then hold ready high until a transfer
  initial begin
    int unsigned gap;
    rgb_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = draw_gap(rx_calm);
      if (gap > 0) begin
        rgb_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rgb_ready_i = 1'b1;
      do @(posedge clk_i); while (!rgb_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin
    rst_ni       = 1'b0;
    hsv_valid_i  = 1'b0;
    hsv_i        = '0;
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, gray, full saturation, every sector edge, wrap
    send_pixel(make_px(0, 0, 0));
    send_pixel(make_px(0, 255, 255));
    send_pixel(make_px(16'hFFFF, 255, 255));
    send_pixel(make_px(16'hFFFF, 0, 0));
    send_pixel(make_px(3000, 0, 200));
    send_pixel(make_px(HueSector - 1, 255, 255));
    send_pixel(make_px(HueSector, 255, 255));
    send_pixel(make_px(2 * HueSector - 1, 255, 255));
    send_pixel(make_px(2 * HueSector, 255, 255));
    send_pixel(make_px(3 * HueSector, 255, 255));
    send_pixel(make_px(4 * HueSector, 255, 255));
    send_pixel(make_px(5 * HueSector, 255, 255));
    send_pixel(make_px(HueTurn - 1, 255, 255));
    send_pixel(make_px(HueTurn, 255, 255));
    send_pixel(make_px(HueTurn + 1, 128, 255));
    send_pixel(make_px(480, 128, 255));
    send_pixel(make_px(2400, 255, 1));
    send_pixel(make_px(16'hAAAA, 8'h55, 8'hAA));
    send_pixel(make_px(16'h5555, 8'hAA, 8'h55));
    send_pixel(make_px(4321, 1, 254));
    wait_drained();

    // Random: switch idle mode every 128 pixels so both busy and calm stretches
    // occur; drain once midway so the pipeline empties and refills.
    for (int i = 0; i < RandomPixels; i++) begin
      if (i % 128 == 0) begin
        tx_calm = $urandom_range(0, 2) == 0;
        rx_calm = $urandom_range(0, 2) == 0;
      end
      if (i == RandomPixels / 2) begin
        wait_drained();
      end
      send_pixel(make_px(pick_hue(), pick_byte(), pick_byte()));
    end
    hsv_valid_i = 1'b0;

    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    sb.flush_check();

    $display("summary: %0d pixels sent, %0d results compared, %0d mismatches",
             sb.pixels_in, sb.pixels_out, sb.errors);
    $display("summary: sector hits %0d %0d %0d %0d %0d %0d", sb.sector_hits[0],
             sb.sector_hits[1], sb.sector_hits[2], sb.sector_hits[3],
             sb.sector_hits[4], sb.sector_hits[5]);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
